### rtl/core/bcpa_pkg.sv
// Shared types, constants and field helpers for the binary curve point block.
// No dependencies.
package bcpa_pkg;

   localparam int FieldBits  = 19;
   localparam int ScalarBits = 19;
   localparam int IdxBits    = 5;    // holds 0..ScalarBits
   localparam int CntBits    = 5;    // multiplier step count and inverse loop count
   localparam int InvLoops   = 17;   // square-and-multiply rounds after the first square

   typedef logic [FieldBits-1:0]  gf_type;
   typedef logic [ScalarBits-1:0] scalar_type;

   // low terms of x^19 + x^5 + x^2 + x + 1
   localparam gf_type RedLow = gf_type'(39);
   localparam gf_type GfOne  = gf_type'(1);

   typedef struct packed {
      logic       func;
      gf_type     p_x;
      gf_type     p_y;
      logic       p_inf;
      gf_type     q_x;
      gf_type     q_y;
      logic       q_inf;
      scalar_type scalar_value;
   } bcpa_req_type;

   typedef struct packed {
      gf_type r_x;
      gf_type r_y;
      logic   r_inf;
      logic   fault;
   } bcpa_rsp_type;

   // multiply by x modulo the field polynomial
   function automatic gf_type gf_xtime(gf_type v);
      gf_type s;
      s = {v[FieldBits-2:0], 1'b0};
      return v[FieldBits-1] ? (s ^ RedLow) : s;
   endfunction

endpackage

### rtl/core/bcpa_gfmul.sv
// Bit-serial GF(2^19) multiplier, one bit of b per cycle, MSB first.
// Depends on bcpa_pkg.
module bcpa_gfmul import bcpa_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   start,
   input  gf_type a,
   input  gf_type b,
   output logic   done,
   output gf_type prod
);

   logic               busy_ff;
   logic               done_ff;
   logic [CntBits-1:0] cnt_ff;
   gf_type             a_ff;
   gf_type             b_ff;
   gf_type             acc_ff;
   gf_type             acc_in;

   assign acc_in = gf_xtime(acc_ff) ^ (b_ff[FieldBits-1] ? a_ff : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            done_ff <= 1'b0;
            cnt_ff  <= '0;
            a_ff    <= a;
            b_ff    <= b;
            acc_ff  <= '0;
         end else if (busy_ff) begin
            acc_ff  <= acc_in;
            b_ff    <= {b_ff[FieldBits-2:0], 1'b0};
            cnt_ff  <= cnt_ff + CntBits'(1);
            done_ff <= (cnt_ff == CntBits'(FieldBits - 1));
            if (cnt_ff == CntBits'(FieldBits - 1)) begin
               busy_ff <= 1'b0;
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

### rtl/core/bcpa_engine.sv
// Point add / double-and-add sequencer driving one shared field multiplier.
// Depends on bcpa_pkg and bcpa_gfmul.
module bcpa_engine import bcpa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  bcpa_req_type req,
   input  logic         out_free,
   output logic         idle,
   output logic         res_valid,
   output bcpa_rsp_type res
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_BIT, ST_CHK, ST_INV0, ST_INVSQ, ST_INVML,
      ST_LAM, ST_LSQ, ST_Y1, ST_Y2, ST_END, ST_FIN
   } state_type;

   state_type          state_ff;
   logic               issued_ff;
   logic               func_ff, phase_ff, bad_ff, dbl_ff;
   scalar_type         n_ff;
   logic [IdxBits-1:0] idx_ff;
   logic [CntBits-1:0] cnt_ff;
   gf_type             px_ff, py_ff, zx_ff, zy_ff, ax_ff, ay_ff, bx_ff, by_ff;
   logic               pinf_ff, zinf_ff, ainf_ff, binf_ff, rinf_ff;
   gf_type             rx_ff, ry_ff, d_ff, sq_ff, inv_ff, l_ff, x_ff, t_ff;

   logic   mul_state, mul_start, mul_done;
   gf_type mul_a, mul_b, prod;
   logic   eqx, opp;

   assign eqx = (ax_ff == bx_ff);
   assign opp = ((ay_ff ^ by_ff) == ax_ff);

   always_comb begin
      mul_state = 1'b1;
      mul_a     = sq_ff;
      mul_b     = sq_ff;
      case (state_ff)
         ST_INV0: begin
            mul_a = d_ff;
            mul_b = d_ff;
         end
         ST_INVSQ: begin
            mul_a = sq_ff;
            mul_b = sq_ff;
         end
         ST_INVML: begin
            mul_a = inv_ff;
            mul_b = sq_ff;
         end
         ST_LAM: begin
            mul_a = dbl_ff ? ay_ff : (ay_ff ^ by_ff);
            mul_b = inv_ff;
         end
         ST_LSQ: begin
            mul_a = l_ff;
            mul_b = l_ff;
         end
         ST_Y1: begin
            mul_a = dbl_ff ? (l_ff ^ GfOne) : l_ff;
            mul_b = dbl_ff ? x_ff : (ax_ff ^ x_ff);
         end
         ST_Y2: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
         default: mul_state = 1'b0;
      endcase
   end

   assign mul_start = mul_state && !issued_ff;

   bcpa_gfmul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         if (mul_done) begin
            issued_ff <= 1'b0;
         end else if (mul_start) begin
            issued_ff <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  func_ff <= req.func;
                  n_ff    <= req.scalar_value;
                  px_ff   <= req.p_x;
                  py_ff   <= req.p_y;
                  pinf_ff <= req.p_inf;
                  ax_ff   <= req.p_x;
                  ay_ff   <= req.p_y;
                  ainf_ff <= req.p_inf;
                  bx_ff   <= req.q_x;
                  by_ff   <= req.q_y;
                  binf_ff <= req.q_inf;
                  zx_ff   <= '0;
                  zy_ff   <= '0;
                  zinf_ff <= 1'b1;
                  bad_ff  <= 1'b0;
                  idx_ff  <= '0;
                  state_ff <= req.func ? ST_BIT : ST_CHK;
               end
            end
            ST_BIT: begin
               if (idx_ff == IdxBits'(ScalarBits)) begin
                  state_ff <= ST_FIN;
               end else begin
                  if (n_ff[idx_ff]) begin
                     ax_ff    <= zx_ff;
                     ay_ff    <= zy_ff;
                     ainf_ff  <= zinf_ff;
                     phase_ff <= 1'b0;
                  end else begin
                     ax_ff    <= px_ff;
                     ay_ff    <= py_ff;
                     ainf_ff  <= pinf_ff;
                     phase_ff <= 1'b1;
                  end
                  bx_ff    <= px_ff;
                  by_ff    <= py_ff;
                  binf_ff  <= pinf_ff;
                  state_ff <= ST_CHK;
               end
            end
            ST_CHK: begin
               if (ainf_ff) begin
                  rx_ff    <= bx_ff;
                  ry_ff    <= by_ff;
                  rinf_ff  <= binf_ff;
                  state_ff <= ST_END;
               end else if (binf_ff) begin
                  rx_ff    <= ax_ff;
                  ry_ff    <= ay_ff;
                  rinf_ff  <= ainf_ff;
                  state_ff <= ST_END;
               end else if (eqx && (opp || (ay_ff != by_ff) || (ax_ff == '0))) begin
                  // opposite points sum to infinity; equal-x pairs neither equal nor opposite fault
                  rx_ff    <= '0;
                  ry_ff    <= '0;
                  rinf_ff  <= 1'b1;
                  state_ff <= ST_END;
                  if (!opp) bad_ff <= 1'b1;
               end else begin
                  // equal x left here only as a doubling
                  dbl_ff   <= eqx;
                  d_ff     <= eqx ? ax_ff : (ax_ff ^ bx_ff);
                  state_ff <= ST_INV0;
               end
            end
            ST_INV0: begin
               if (mul_done) begin
                  sq_ff    <= prod;
                  inv_ff   <= prod;
                  cnt_ff   <= '0;
                  state_ff <= ST_INVSQ;
               end
            end
            ST_INVSQ: begin
               if (mul_done) begin
                  sq_ff    <= prod;
                  state_ff <= ST_INVML;
               end
            end
            ST_INVML: begin
               if (mul_done) begin
                  inv_ff <= prod;
                  cnt_ff <= cnt_ff + CntBits'(1);
                  state_ff <= (cnt_ff == CntBits'(InvLoops - 1)) ? ST_LAM : ST_INVSQ;
               end
            end
            ST_LAM: begin
               if (mul_done) begin
                  l_ff     <= dbl_ff ? (ax_ff ^ prod) : prod;
                  state_ff <= ST_LSQ;
               end
            end
            ST_LSQ: begin
               if (mul_done) begin
                  x_ff <= dbl_ff ? (prod ^ l_ff ^ GfOne)
                                 : (prod ^ l_ff ^ ax_ff ^ bx_ff ^ GfOne);
                  state_ff <= ST_Y1;
               end
            end
            ST_Y1: begin
               if (mul_done) begin
                  rx_ff   <= x_ff;
                  rinf_ff <= 1'b0;
                  if (dbl_ff) begin
                     t_ff     <= prod;
                     state_ff <= ST_Y2;
                  end else begin
                     ry_ff    <= prod ^ x_ff ^ ay_ff;
                     state_ff <= ST_END;
                  end
               end
            end
            ST_Y2: begin
               if (mul_done) begin
                  ry_ff    <= prod ^ t_ff;
                  state_ff <= ST_END;
               end
            end
            ST_END: begin
               if (!func_ff || !phase_ff) begin
                  zx_ff   <= rx_ff;
                  zy_ff   <= ry_ff;
                  zinf_ff <= rinf_ff;
               end
               if (!func_ff) begin
                  state_ff <= ST_FIN;
               end else if (!phase_ff) begin
                  ax_ff    <= px_ff;
                  ay_ff    <= py_ff;
                  ainf_ff  <= pinf_ff;
                  phase_ff <= 1'b1;
                  state_ff <= ST_CHK;
               end else begin
                  px_ff    <= rx_ff;
                  py_ff    <= ry_ff;
                  pinf_ff  <= rinf_ff;
                  idx_ff   <= idx_ff + IdxBits'(1);
                  state_ff <= ST_BIT;
               end
            end
            ST_FIN: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_FIN);
   assign res.r_x   = (bad_ff || zinf_ff) ? '0 : zx_ff;
   assign res.r_y   = (bad_ff || zinf_ff) ? '0 : zy_ff;
   assign res.r_inf = !bad_ff && zinf_ff;
   assign res.fault = bad_ff;

`ifndef SYNTH
   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> issued_ff) else $error("multiplier finished without a request");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !issued_ff) else $error("multiply pending while idle");
   a_fault_clean: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !(res.fault && res.r_inf)) else $error("fault result marked infinity");
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !out_free) |=> res_valid) else $error("result dropped while stalled");
`endif

endmodule

### rtl/core/binary_curve_point_arith_top.sv
// Top level of the GF(2^19) binary curve point arithmetic block.
// Depends on bcpa_pkg and bcpa_engine.
//
// Usage:
//  - Request channel req_*: one word per operation. req_tuser is the
//    operation (0 point add P+Q, 1 scalar multiply n*P); req_tdata holds the
//    operands. Only one operation is in flight; req_tready is high while
//    the engine is idle and reset is low.
//  - Result channel rsp_*: exactly one word per request. rsp_tuser is the
//    fault flag (equal-x operands that are neither equal nor opposite); then
//    all result fields are zero.
//  - Work: a field multiply runs 19 bit steps plus load and hand-back; a
//    field inverse is 35 multiplies. Point add finishes early when an
//    operand is infinity or the sum is trivial, else it takes 38
//    multiplies, or 39 for a doubling. Scalar multiply: one double per bit
//    over 19 bits plus one add per set bit. All multiplies go through the
//    single shared multiplier.
//  - Stall: a finished result sits in the rsp output register; the engine
//    holds its next result until that register frees up, and takes a new
//    request as soon as it has handed its result over.
//  - Reset (synchronous, active high) returns the engine to idle and empties
//    the output register.
module binary_curve_point_arith_top import bcpa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // p_x[18:0] p_y[37:19] p_inf[38] q_x[57:39] q_y[76:58] q_inf[77]
   // scalar_value[96:78], zero pad [103:97]
   input  logic [103:0] req_tdata,
   // func[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // r_x[18:0] r_y[37:19] r_inf[38], zero pad [39]
   output logic [39:0]  rsp_tdata,
   // fault[0]
   output logic [0:0]   rsp_tuser
);

   bcpa_req_type req;
   bcpa_rsp_type res, rsp_ff;
   logic         eng_idle, res_valid, out_free, rsp_valid_ff;

   assign req.func         = req_tuser[0];
   assign req.p_x          = req_tdata[18:0];
   assign req.p_y          = req_tdata[37:19];
   assign req.p_inf        = req_tdata[38];
   assign req.q_x          = req_tdata[57:39];
   assign req.q_y          = req_tdata[76:58];
   assign req.q_inf        = req_tdata[77];
   assign req.scalar_value = req_tdata[96:78];

   // output register free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   bcpa_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid),
      .req       (req),
      .out_free  (out_free),
      .idle      (eng_idle),
      .res_valid (res_valid),
      .res       (res)
   );

   assign req_tready = eng_idle && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (res_valid && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= res;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {1'b0, rsp_ff.r_inf, rsp_ff.r_y, rsp_ff.r_x};
   assign rsp_tuser[0] = rsp_ff.fault;

endmodule
